[rtl/mpkt_pkg.sv]
// ----------------------------------------------------------------------------
// mpkt_pkg
// Shared widths, constants and types for the k-transaction profit tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mpkt_pkg;

    localparam int PRICE_W              = 17;
    localparam int PROFIT_W             = 30;
    localparam int HOLD_W               = 32;
    localparam int CFG_W                = 7;
    localparam int S_TDATA_W            = 24;
    localparam int M_TDATA_W            = 32;
    localparam int DEF_MAX_TRANSACTIONS = 64;

    localparam logic [CFG_W-1:0]    CFG_RESET  = CFG_W'(2);
    localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};
    localparam logic [HOLD_W-1:0]   HOLD_MIN   = {1'b1, {(HOLD_W-1){1'b0}}};

    // per-level control from the top level
    typedef struct packed {
        logic update;  // apply one day's price
        logic clear;   // final day: load the reset values in place of the update
    } lvl_ctrl_t;

endpackage

`default_nettype wire

[rtl/mpkt_level.sv]
// ----------------------------------------------------------------------------
// mpkt_level
// One transaction level: best holding value and best flat value, updated
// once per day from the price and the new flat value of the level below.
// ----------------------------------------------------------------------------
`default_nettype none

module mpkt_level
    import mpkt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lvl_ctrl_t           ctrl,
    input  wire logic [PRICE_W-1:0]  price,
    input  wire logic [PROFIT_W-1:0] flat_below,
    output logic [PROFIT_W-1:0]      flat_new,
    output logic [PROFIT_W-1:0]      flat_cur,
    output logic [HOLD_W-1:0]        hold_cur
);

    logic [HOLD_W-1:0]   hold_reg;
    logic [HOLD_W-1:0]   hold_next;
    logic [PROFIT_W-1:0] flat_reg;
    logic [PROFIT_W-1:0] flat_next;

    logic signed [HOLD_W:0]   sell;
    logic signed [HOLD_W:0]   flat_ext;
    logic signed [HOLD_W:0]   best;
    logic signed [HOLD_W-1:0] buy;

    always_comb
    begin
        // sell today with the holding from before today
        sell     = $signed({hold_reg[HOLD_W-1], hold_reg})
                   + $signed({{(HOLD_W+1-PRICE_W){1'b0}}, price});
        flat_ext = $signed({{(HOLD_W+1-PROFIT_W){1'b0}}, flat_reg});
        best     = (sell > flat_ext) ? sell : flat_ext;
        if (best > $signed({{(HOLD_W+1-PROFIT_W){1'b0}}, PROFIT_MAX}))
        begin
            flat_new = PROFIT_MAX;
        end
        else
        begin
            flat_new = best[PROFIT_W-1:0];
        end

        // buy today out of the level below after its sell
        buy = $signed({{(HOLD_W-PROFIT_W){1'b0}}, flat_below})
              - $signed({{(HOLD_W-PRICE_W){1'b0}}, price});

        flat_next = flat_reg;
        hold_next = hold_reg;
        if (ctrl.update)
        begin
            if (ctrl.clear)
            begin
                flat_next = '0;
                hold_next = HOLD_MIN;
            end
            else
            begin
                flat_next = flat_new;
                hold_next = (buy > $signed(hold_reg)) ? buy : hold_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flat_reg <= '0;
            hold_reg <= HOLD_MIN;
        end
        else
        begin
            flat_reg <= flat_next;
            hold_reg <= hold_next;
        end
    end

    assign flat_cur = flat_reg;
    assign hold_cur = hold_reg;

endmodule

`default_nettype wire

[rtl/max_profit_k_transactions_unit.sv]
// ----------------------------------------------------------------------------
// max_profit_k_transactions_unit
// Maximum trading profit with at most a configured number of transactions.
// ----------------------------------------------------------------------------
// Prices stream in on the s_ side, one day per request; s_tlast marks the
// final day of a series. For that day one result request leaves on the m_
// side carrying the best profit with at most cfg transactions (0 for a limit
// of 0, limits above MAX_TRANSACTIONS act as MAX_TRANSACTIONS). Other days
// produce no result.
// Every level of the table updates in parallel, so one price is taken every
// cycle while s_tready is high; the cost per day is one add-and-max, a
// saturate and one subtract-and-max inside each level. A price is registered
// at the input and applied to the table when it moves on, where a final-day
// result is also written to the output register that drives m_tvalid. While
// a result waits on m_tready, further prices still enter; only a second final
// day stalls s_tready until the first result is taken.
// Reset sets the limit to 2 and clears the table (flat 0, holding at the
// most negative value); the table is cleared again after each final day.
// cfg_we writes the limit at any edge and is meant to be used while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module max_profit_k_transactions_unit
    import mpkt_pkg::*;
#(
    parameter int MAX_TRANSACTIONS = DEF_MAX_TRANSACTIONS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [16:0] price, rest zero
    input  wire logic                 s_tlast,   // last_day
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [29:0] profit, rest zero
    input  wire logic                 cfg_we,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    localparam int LVL_W = (MAX_TRANSACTIONS > 1) ? $clog2(MAX_TRANSACTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_TRANSACTIONS + 1);
    localparam int K_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [CFG_W-1:0]    limit_reg;
    logic                in_valid_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [PROFIT_W-1:0] profit_reg;

    logic                advance;
    lvl_ctrl_t           ctrl;
    logic [K_W-1:0]      k_eff;
    logic [LVL_W-1:0]    sel;
    logic [PROFIT_W-1:0] profit_next;

    logic [PROFIT_W-1:0] flat_new [MAX_TRANSACTIONS];
    logic [PROFIT_W-1:0] flat_cur [MAX_TRANSACTIONS];
    logic [HOLD_W-1:0]   hold_cur [MAX_TRANSACTIONS];

    // a final day may only move on when the output register can take it
    assign advance  = in_valid_reg && !(last_reg && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign ctrl.update = advance;
    assign ctrl.clear  = last_reg;

    generate
        for (genvar i = 0; i < MAX_TRANSACTIONS; i++)
        begin : g_lvl
            mpkt_level u_level (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .price      (price_reg),
                .flat_below ((i == 0) ? '0 : flat_new[(i == 0) ? 0 : i-1]),
                .flat_new   (flat_new[i]),
                .flat_cur   (flat_cur[i]),
                .hold_cur   (hold_cur[i])
            );
        end
    endgenerate

    always_comb
    begin
        k_eff = K_W'(limit_reg);
        if (k_eff > K_W'(MAX_TRANSACTIONS))
        begin
            k_eff = K_W'(MAX_TRANSACTIONS);
        end
        sel = LVL_W'(k_eff - K_W'(1));
        if (k_eff == '0)
        begin
            profit_next = '0;
        end
        else
        begin
            profit_next = flat_new[sel];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= CFG_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end

            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            price_reg <= s_tdata[PRICE_W-1:0];
            last_reg  <= s_tlast;
        end
        if (advance && last_reg)
        begin
            profit_reg <= profit_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(profit_reg);

    // a final day always lands in the output register
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> m_tvalid)
        else $error("final day did not produce a result");

    // a result appears only after a final day moved on
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(advance && last_reg))
        else $error("result without a final day");

    // level 0 of the table is back at its reset values after a final day
    a_table_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_reg |=> flat_cur[0] == '0 && hold_cur[0] == HOLD_MIN)
        else $error("table not cleared after final day");

    // the input stage stalls only on a final day blocked by a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && last_reg && m_tvalid && !m_tready)
        else $error("input stalled without cause");

endmodule

`default_nettype wire
